// ===== hw/rtl/qte_pkg.sv =====
// ----------------------------------------------------------------------------
// qte_pkg
// Types, constants and the CORDIC step shared by the quaternion to Euler
// angle converter.
// ----------------------------------------------------------------------------
package qte_pkg;

  // default CORDIC depth and the arctangent table length
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN          = 24;

  // bit-serial square root steps: root of a value up to 2^60
  localparam int SQRT_STEPS = 31;

  // queue depths (powers of two)
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  // widths
  localparam int TW = 34;  // products and sums, 2^30 = 1.0
  localparam int CW = 37;  // CORDIC vector, room for gain and sign flip
  localparam int AW = 32;  // binary angle accumulator, 2^31 = pi

  localparam logic [AW-1:0] ATAN_TAB [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  localparam logic [AW-1:0] ANG_PI = 32'h8000_0000;
  localparam logic signed [15:0] ANG_HALF_PI = 16'sd16384;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } qte_in_t;

  typedef struct packed {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic               gimbal_clamped;
  } qte_out_t;

  // classified word between front and back
  typedef struct packed {
    logic signed [TW-1:0] sr;
    logic signed [TW-1:0] cr;
    logic signed [TW-1:0] sy;
    logic signed [TW-1:0] cy;
    logic signed [TW-1:0] sp;
  } qte_mid_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [AW-1:0]        acc;
  } qte_cordic_t;

  // one back pipeline stage
  typedef struct packed {
    logic        gim;
    logic        sneg;
    logic        xzero;
    logic        zzero;
    qte_cordic_t cx;
    qte_cordic_t cz;
    qte_cordic_t cy;
    logic [59:0] s2;
    logic [60:0] rem;
    logic [60:0] root;
    logic signed [30:0] sv;
  } qte_stage_t;

  // one vectoring CORDIC iteration; zero sine counts as not positive
  function automatic qte_cordic_t cordic_step(qte_cordic_t c, int i);
    qte_cordic_t r;
    r = c;
    if (c.y > 0) begin
      r.x   = c.x + (c.y >>> i);
      r.y   = c.y - (c.x >>> i);
      r.acc = c.acc + ATAN_TAB[i];
    end else begin
      r.x   = c.x - (c.y >>> i);
      r.y   = c.y + (c.x >>> i);
      r.acc = c.acc - ATAN_TAB[i];
    end
    return r;
  endfunction

  // binary angle rounded half up to 16 bits
  function automatic logic signed [15:0] ang_round(logic [AW-1:0] acc);
    return acc[31:16] + {15'd0, acc[15]};
  endfunction

endpackage

// ===== hw/rtl/qte_fifo.sv =====
// ----------------------------------------------------------------------------
// qte_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module qte_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [NW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == NW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= wdata;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      if (do_pop)  rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      cnt_r <= cnt_r + NW'(do_push) - NW'(do_pop);
    end
  end

endmodule

// ===== hw/rtl/qte_front.sv =====
// ----------------------------------------------------------------------------
// qte_front
// Accepts quaternions, forms the products, then the sine/cosine terms that
// go to the middle queue.
// ----------------------------------------------------------------------------
module qte_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  qte_pkg::qte_in_t  in_word,
  output logic              full,
  output logic              mid_push,
  output qte_pkg::qte_mid_t mid_word,
  input  logic              mid_full
);
  import qte_pkg::*;

  logic signed [31:0] wx_r, yz_r, xx_r, yy_r, wz_r, xy_r, zz_r, wy_r, zx_r;
  logic               vld_r;
  logic               adv;

  // product stage moves unless its word is stuck on a full queue
  assign adv      = !vld_r || !mid_full;
  assign full     = !adv;
  assign mid_push = vld_r && !mid_full;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (adv) vld_r <= push;
  end

  // products of the components
  always_ff @(posedge clk) begin
    if (adv && push) begin
      wx_r <= in_word.quat_w * in_word.quat_x;
      yz_r <= in_word.quat_y * in_word.quat_z;
      xx_r <= in_word.quat_x * in_word.quat_x;
      yy_r <= in_word.quat_y * in_word.quat_y;
      wz_r <= in_word.quat_w * in_word.quat_z;
      xy_r <= in_word.quat_x * in_word.quat_y;
      zz_r <= in_word.quat_z * in_word.quat_z;
      wy_r <= in_word.quat_w * in_word.quat_y;
      zx_r <= in_word.quat_z * in_word.quat_x;
    end
  end

  // sine and cosine terms, 2^30 = 1.0
  always_comb begin
    mid_word.sr = (TW'(wx_r) + TW'(yz_r)) <<< 1;
    mid_word.cr = (TW'(1) <<< 30) - ((TW'(xx_r) + TW'(yy_r)) <<< 1);
    mid_word.sy = (TW'(wz_r) + TW'(xy_r)) <<< 1;
    mid_word.cy = (TW'(1) <<< 30) - ((TW'(yy_r) + TW'(zz_r)) <<< 1);
    mid_word.sp = (TW'(wy_r) - TW'(zx_r)) <<< 1;
  end

endmodule

// ===== hw/rtl/qte_back.sv =====
// ----------------------------------------------------------------------------
// qte_back
// Stalling pipeline: clamp test and square, bit-serial square root, three
// vectoring CORDICs, rounding to 16-bit binary angles.
// ----------------------------------------------------------------------------
module qte_back #(
  parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  qte_pkg::qte_mid_t mid_word,
  input  logic              mid_empty,
  output logic              mid_pop,
  output logic              out_push,
  output qte_pkg::qte_out_t out_word,
  input  logic              out_full
);
  import qte_pkg::*;

  localparam int D = SQRT_STEPS + CORDIC_STAGES;

  qte_stage_t st_r   [D+1];
  qte_stage_t st_nxt [D+1];
  logic [D:0] vld_r;
  logic       adv;

  // whole pipeline holds while the last word cannot leave
  assign adv      = !(vld_r[D] && out_full);
  assign mid_pop  = adv && !mid_empty;
  assign out_push = adv && vld_r[D];

  // stage 0: clamp test, s squared, X/Z vector setup
  always_comb begin
    logic signed [CW-1:0] xr, yr, xz, yz;
    logic signed [61:0]   sq;
    st_nxt[0]       = '0;
    st_nxt[0].gim   = (mid_word.sp >= (TW'(1) <<< 30)) || (mid_word.sp <= -(TW'(1) <<< 30));
    st_nxt[0].sneg  = mid_word.sp[TW-1];
    st_nxt[0].sv    = mid_word.sp[30:0];
    sq              = st_nxt[0].sv * st_nxt[0].sv;
    st_nxt[0].s2    = sq[59:0];
    xr = CW'(mid_word.cr);
    yr = CW'(mid_word.sr);
    xz = CW'(mid_word.cy);
    yz = CW'(mid_word.sy);
    st_nxt[0].xzero = (xr == '0) && (yr == '0);
    st_nxt[0].zzero = (xz == '0) && (yz == '0);
    // negative cosine: rotate by pi first
    if (xr < 0) begin
      st_nxt[0].cx = '{x: -xr, y: -yr, acc: ANG_PI};
    end else begin
      st_nxt[0].cx = '{x: xr, y: yr, acc: '0};
    end
    if (xz < 0) begin
      st_nxt[0].cz = '{x: -xz, y: -yz, acc: ANG_PI};
    end else begin
      st_nxt[0].cz = '{x: xz, y: yz, acc: '0};
    end
  end

  // stages 1..D
  for (genvar j = 1; j <= D; j++) begin : g_stage
    always_comb begin
      qte_stage_t t;
      logic [61:0] b, sum;
      t = st_r[j-1];
      b = '0;
      sum = '0;
      // square root of 2^60 - s^2: setup in stage 1, then one root bit per stage
      if (j == 1) begin
        if (t.s2 == '0) begin
          t.rem  = '0;
          t.root = 61'(62'd1 << 60);
        end else begin
          t.rem  = 61'(62'd1 << 60) - 61'(t.s2);
          t.root = '0;
        end
      end else if (j <= SQRT_STEPS) begin
        b   = 62'd1 << (2 * (SQRT_STEPS - j));
        sum = 62'(t.root) + b;
        if (62'(t.rem) >= sum) begin
          t.rem  = t.rem - 61'(sum);
          t.root = 61'(62'(t.root >> 1) + b);
        end else begin
          t.root = t.root >> 1;
        end
      end
      // X and Z angles
      if (j <= CORDIC_STAGES) begin
        t.cx = cordic_step(t.cx, j - 1);
        t.cz = cordic_step(t.cz, j - 1);
      end
      // Y angle: atan2(s, root)
      if (j == SQRT_STEPS + 1) begin
        t.cy = '{x: CW'(t.root), y: CW'(t.sv), acc: '0};
      end
      if (j > SQRT_STEPS) begin
        t.cy = cordic_step(t.cy, j - SQRT_STEPS - 1);
      end
      st_nxt[j] = t;
    end
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= D; k++) st_r[k] <= st_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[D-1:0], mid_pop};
  end

  // result word
  always_comb begin
    out_word.angle_x = st_r[D].xzero ? '0 : ang_round(st_r[D].cx.acc);
    out_word.angle_z = st_r[D].zzero ? '0 : ang_round(st_r[D].cz.acc);
    if (st_r[D].gim) begin
      out_word.angle_y = st_r[D].sneg ? -ANG_HALF_PI : ANG_HALF_PI;
    end else begin
      out_word.angle_y = ang_round(st_r[D].cy.acc);
    end
    out_word.gimbal_clamped = st_r[D].gim;
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !out_full) else $error("result word pushed into full queue");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[D] && out_full) |=> vld_r[D]) else $error("stalled word lost");
  a_clamp_angle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_push && out_word.gimbal_clamped) |->
      (out_word.angle_y == ANG_HALF_PI || out_word.angle_y == -ANG_HALF_PI))
    else $error("clamped Y angle not at half pi");
`endif

endmodule

// ===== hw/rtl/quaternion_to_euler_angles.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Q1.15 quaternion in, X/Y/Z Euler angles as 16-bit binary angles out.
// ----------------------------------------------------------------------------
// One word in and one word out per clock in steady state while the output
// queue is not full. An accepted word is loaded into the product stage,
// then passes through the middle queue, one setup stage, 31 square root
// stages (the Y cosine), CORDIC_STAGES Y CORDIC stages, and into the output
// queue; the X and Z CORDICs run alongside the square root. A full output
// queue stalls the back pipeline and then, through the middle queue, the
// input side.
module quaternion_to_euler_angles #(
  parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  qte_pkg::qte_in_t  in_word,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output qte_pkg::qte_out_t out_word
);
  import qte_pkg::*;

  qte_mid_t f_word, m_word;
  qte_out_t b_word;
  logic     f_push, m_full, m_empty, m_pop, b_push, o_full;

  qte_front u_front (
    .clk, .rst_n, .push, .in_word, .full,
    .mid_push(f_push), .mid_word(f_word), .mid_full(m_full)
  );

  qte_fifo #(.W($bits(qte_mid_t)), .DEPTH(MID_DEPTH)) u_mid (
    .clk, .rst_n, .push(f_push), .wdata(f_word), .full(m_full),
    .pop(m_pop), .rdata(m_word), .empty(m_empty)
  );

  qte_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
    .clk, .rst_n, .mid_word(m_word), .mid_empty(m_empty), .mid_pop(m_pop),
    .out_push(b_push), .out_word(b_word), .out_full(o_full)
  );

  qte_fifo #(.W($bits(qte_out_t)), .DEPTH(OUT_DEPTH)) u_out (
    .clk, .rst_n, .push(b_push), .wdata(b_word), .full(o_full),
    .pop, .rdata(out_word), .empty
  );

endmodule

// ===== tb/sv/quaternion_to_euler_angles_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_tb
// Drives quaternions through the converter with random push and pop gaps and
// checks every word against a bit-exact fixed-point CORDIC model or typed row.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_tb;
  import qte_pkg::*;

  localparam int STAGES      = CORDIC_STAGES_DEF;
  localparam int N_RANDOM    = 400;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_WAIT  = STAGES + 60;

  logic     clk;
  logic     rst_n;
  logic     push;
  qte_in_t  in_word;
  logic     full;
  logic     empty;
  logic     pop;
  qte_out_t out_word;

  quaternion_to_euler_angles #(.CORDIC_STAGES(STAGES)) dut (
    .clk(clk), .rst_n(rst_n), .push(push), .in_word(in_word), .full(full),
    .empty(empty), .pop(pop), .out_word(out_word)
  );

  // directed row: quaternion, plus an optional hand-typed expected word
  typedef struct {
    qte_in_t  q;
    bit       typed;
    qte_out_t ang;
  } quat_row_t;

  qte_out_t  angle_q[$];
  int        n_errors;
  int        n_words_in = 0;
  int        n_words_out;
  int        n_gimbal;
  int        idle_cycles = 0;
  bit        stim_done;
  bit        no_gaps;

  // ---------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------
  function automatic logic signed [15:0] atan2_bam(longint y_in, longint x_in);
    longint   vx, vy, nx, ny;
    bit [31:0] acc;
    if (x_in == 0 && y_in == 0) return 16'sd0;
    vx  = x_in;
    vy  = y_in;
    acc = 32'd0;
    if (vx < 0) begin
      vx  = -vx;
      vy  = -vy;
      acc = ANG_PI;
    end
    for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
      if (vy > 0) begin
        nx  = vx + (vy >>> i);
        ny  = vy - (vx >>> i);
        acc = acc + ATAN_TAB[i];
      end else begin
        nx  = vx - (vy >>> i);
        ny  = vy + (vx >>> i);
        acc = acc - ATAN_TAB[i];
      end
      vx = nx;
      vy = ny;
    end
    acc = acc + 32'h8000;
    return acc[31:16];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic qte_out_t euler_of(qte_in_t q);
    longint   qx, qy, qz, qw, sr, cr, sy, cy, s, one;
    longint unsigned c;
    qte_out_t r;
    one = longint'(1) << 30;
    qx  = q.quat_x;
    qy  = q.quat_y;
    qz  = q.quat_z;
    qw  = q.quat_w;
    sr  = 2 * (qw * qx + qy * qz);
    cr  = one - 2 * (qx * qx + qy * qy);
    sy  = 2 * (qw * qz + qx * qy);
    cy  = one - 2 * (qy * qy + qz * qz);
    s   = 2 * (qw * qy - qz * qx);
    r.gimbal_clamped = (s >= one || s <= -one);
    if (r.gimbal_clamped) begin
      r.angle_y = (s > 0) ? ANG_HALF_PI : -ANG_HALF_PI;
    end else begin
      c = int_sqrt((64'd1 << 60) - longint'(s * s));
      r.angle_y = atan2_bam(s, longint'(c));
    end
    r.angle_x = atan2_bam(sr, cr);
    r.angle_z = atan2_bam(sy, cy);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch word %0d %s: got %0d expected %0d", n_words_out, what, got, want);
    n_errors++;
  endtask

  function automatic qte_in_t mk(int x, int y, int z, int w);
    qte_in_t q;
    q.quat_x = 16'(x);
    q.quat_y = 16'(y);
    q.quat_z = 16'(z);
    q.quat_w = 16'(w);
    return q;
  endfunction

  // ---------------------------------------------------------------------
  // clock and reset
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------
  // stimulus: directed table, then random quaternions
  // ---------------------------------------------------------------------
  initial begin
    quat_row_t rows[$];
    quat_row_t row;
    int        k;
    // identity, zero, and clamped extremes (cosine terms negative: X, Z at pi)
    row.typed = 1'b1;
    row.q = mk(0, 0, 0, 32767);
    row.ang = '{16'sd0, 16'sd0, 16'sd0, 1'b0};  rows.push_back(row);
    row.q = mk(0, 0, 0, 0);
    row.ang = '{16'sd0, 16'sd0, 16'sd0, 1'b0};  rows.push_back(row);
    row.q = mk(0, -32768, 0, 32767);
    row.ang = '{16'sh8000, -16'sd16384, 16'sh8000, 1'b1}; rows.push_back(row);
    row.q = mk(0, -32768, 0, -32768);
    row.ang = '{16'sh8000, 16'sd16384, 16'sh8000, 1'b1}; rows.push_back(row);
    row.typed = 1'b0;
    row.q = mk(0, 23170, 0, 23170);    rows.push_back(row);
    row.q = mk(0, -23170, 0, 23170);   rows.push_back(row);
    row.q = mk(-32768, 0, 0, 0);       rows.push_back(row);
    row.q = mk(32767, 0, 0, 0);        rows.push_back(row);
    row.q = mk(0, 32767, 0, 0);        rows.push_back(row);
    row.q = mk(0, 0, -32768, 0);       rows.push_back(row);
    row.q = mk(0, 0, 0, -32768);       rows.push_back(row);
    row.q = mk(-32768, -32768, -32768, -32768); rows.push_back(row);
    row.q = mk(32767, 32767, 32767, 32767);     rows.push_back(row);
    row.q = mk(32767, -32768, 32767, -32768);   rows.push_back(row);
    row.q = mk(23170, 0, 0, 23170);    rows.push_back(row);
    row.q = mk(0, 0, 23170, 23170);    rows.push_back(row);
    row.q = mk(16384, 16384, 16384, 16384); rows.push_back(row);
    row.q = mk(1, 0, 0, 0);            rows.push_back(row);
    row.q = mk(0, 0, 0, -1);           rows.push_back(row);
    row.q = mk(-1, -1, -1, -1);        rows.push_back(row);
    row.q = mk(-16384, 16384, -16384, 16384); rows.push_back(row);

    // pre-build the random part: moderate, near-gimbal and raw noise words
    for (int i = 0; i < N_RANDOM; i++) begin
      row.typed = 1'b0;
      k = $urandom_range(0, 9);
      if (k < 6) begin
        // random quaternion: all four components in -20000..20000
        row.q = mk($urandom_range(0, 40000) - 20000, $urandom_range(0, 40000) - 20000,
                   $urandom_range(0, 40000) - 20000, $urandom_range(0, 40000) - 20000);
      end else if (k < 8) begin
        // near gimbal: y and w close to +-0.707
        row.q = mk($urandom_range(0, 600) - 300, $urandom_range(22800, 23500),
                   $urandom_range(0, 600) - 300, $urandom_range(22800, 23500));
        if ($urandom_range(0, 1)) row.q.quat_y = -row.q.quat_y;
        if ($urandom_range(0, 1)) row.q.quat_w = -row.q.quat_w;
      end else begin
        row.q = qte_in_t'({$urandom, $urandom});
      end
      rows.push_back(row);
    end

    push    <= 1'b0;
    in_word <= '0;
    stim_done = 1'b0;
    @(posedge clk);
    wait (rst_n === 1'b1);
    @(posedge clk);
    foreach (rows[i]) begin
      // random idle gaps except in the no-gap stretch
      no_gaps = (i >= 150 && i < 250);
      while (!no_gaps && $urandom_range(0, 99) < 23) begin
        push <= 1'b0;
        @(posedge clk);
      end
      push    <= 1'b1;
      in_word <= rows[i].q;
      angle_q.push_back(rows[i].typed ? rows[i].ang : euler_of(rows[i].q));
      @(posedge clk);
      while (full) @(posedge clk);
    end
    push <= 1'b0;
    stim_done = 1'b1;
  end

  // ---------------------------------------------------------------------
  // output side: random pop, compare accepted words
  // ---------------------------------------------------------------------
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) begin
        if (angle_q.size() == 0) begin
          $display("unexpected output word %0d", n_words_out);
          n_errors++;
        end else begin
          qte_out_t e;
          e = angle_q.pop_front();
          if (out_word.angle_x !== e.angle_x)
            report_mismatch("angle_x", out_word.angle_x, e.angle_x);
          if (out_word.angle_y !== e.angle_y)
            report_mismatch("angle_y", out_word.angle_y, e.angle_y);
          if (out_word.angle_z !== e.angle_z)
            report_mismatch("angle_z", out_word.angle_z, e.angle_z);
          if (out_word.gimbal_clamped !== e.gimbal_clamped)
            report_mismatch("gimbal_clamped", out_word.gimbal_clamped, e.gimbal_clamped);
          n_gimbal += e.gimbal_clamped;
        end
        n_words_out++;
      end
      pop <= (n_words_out > 150 && n_words_out < 250) ? 1'b1 : ($urandom_range(0, 99) >= 23);
    end
  end

  // ---------------------------------------------------------------------
  // watchdog, accepted input count, end of run
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && push && !full) n_words_in <= n_words_in + 1;
    if ((rst_n && push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    n_errors = 0;
    n_words_out = 0;
    n_gimbal = 0;
    fork
      begin
        wait (stim_done && angle_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
      end
      begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
        n_errors++;
      end
    join_any
    $display("converted %0d quaternions, %0d words checked, %0d gimbal clamps",
             n_words_in, n_words_out, n_gimbal);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d errors", n_errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/qte_pkg.sv
hw/rtl/qte_fifo.sv
hw/rtl/qte_front.sv
hw/rtl/qte_back.sv
hw/rtl/quaternion_to_euler_angles.sv
tb/sv/quaternion_to_euler_angles_tb.sv
